// File: src/bres_pkg.sv
// ----------------------------------------------------------------------------
// bres_pkg
// Shared constants, command codes and the controller-to-datapath command
// struct for the Burgers Richtmyer stencil step.
// ----------------------------------------------------------------------------
package bres_pkg;

	localparam int RATIO_W     = 15;
	localparam int RATIO_FRAC  = 14;
	localparam int FLUX_SHIFT  = 13;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 15'd14746;

	// micro-steps of one interior update
	localparam int NSTEPS = 16;
	localparam int STEP_W = $clog2(NSTEPS);

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_SQ_R,
		MUL_SQ_C,
		MUL_SQ_L,
		MUL_SQ_UP,
		MUL_SQ_UM,
		MUL_RD
	} mul_op_t;

	typedef enum logic [2:0] {
		WB_NONE,
		WB_F_R,
		WB_F_C,
		WB_F_L,
		WB_F_UP,
		WB_F_UM,
		WB_P
	} wb_op_t;

	typedef enum logic [2:0] {
		ALU_NONE,
		ALU_D_RC,
		ALU_D_CL,
		ALU_D_UPUM,
		ALU_FACE_UP,
		ALU_FACE_UM,
		ALU_UPDATE
	} alu_op_t;

	typedef enum logic [2:0] {
		WIN_NONE,
		WIN_LOAD_C,
		WIN_SHIFT_IN,
		WIN_LOAD_R,
		WIN_SHIFT_R
	} win_op_t;

	typedef enum logic [1:0] {
		OUT_NONE,
		OUT_SAMPLE,
		OUT_RESULT,
		OUT_RIGHT
	} out_sel_t;

	typedef struct packed {
		mul_op_t  mul_op;
		wb_op_t   wb_op;
		alu_op_t  alu_op;
		win_op_t  win_op;
		out_sel_t out_sel;
		logic     out_last;
	} bres_cmd_t;

	localparam bres_cmd_t CMD_IDLE = '{
		mul_op:   MUL_NONE,
		wb_op:    WB_NONE,
		alu_op:   ALU_NONE,
		win_op:   WIN_NONE,
		out_sel:  OUT_NONE,
		out_last: 1'b0
	};

endpackage

// File: src/bres_if.sv
// ----------------------------------------------------------------------------
// bres_if
// Channel interfaces: grid sample input, result output, ratio write port.
// ----------------------------------------------------------------------------
interface bres_in_if #(parameter int VALUE_WIDTH = 16);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] sample;
	logic                          row_end;

	modport source (output valid, sample, row_end, input ready);
	modport sink (input valid, sample, row_end, output ready);
endinterface

interface bres_out_if #(parameter int VALUE_WIDTH = 16);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] new_value;
	logic                          last_out;

	modport source (output valid, new_value, last_out, input ready);
	modport sink (input valid, new_value, last_out, output ready);
endinterface

interface bres_cfg_if import bres_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [RATIO_W-1:0] courant_ratio;

	modport source (output valid, courant_ratio, input ready);
	modport sink (input valid, courant_ratio, output ready);
endinterface

// File: src/bres_datapath.sv
// ----------------------------------------------------------------------------
// bres_datapath
// Window registers, one shared multiplier with registered product, rounding
// and saturation write-back, a small ALU and the output register.
// ----------------------------------------------------------------------------
module bres_datapath import bres_pkg::*; #(
	parameter int VALUE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bres_cmd_t                     cmd,
	input  logic signed [VALUE_WIDTH-1:0] sample,
	input  logic                          cfg_we,
	input  logic [RATIO_W-1:0]            cfg_data,
	output logic signed [VALUE_WIDTH-1:0] new_value,
	output logic                          last_out
);

	localparam int W  = VALUE_WIDTH;
	localparam int MB = (W > RATIO_W + 1) ? W : RATIO_W + 1;
	localparam int PW = W + MB;
	localparam int SW = PW + 2;

	localparam logic signed [SW-1:0] VMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [SW-1:0] VMIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic signed [SW-1:0] FLUX_HALF  = SW'(2 ** (FLUX_SHIFT - 1));
	localparam logic signed [SW-1:0] RATIO_HALF = SW'(2 ** (RATIO_FRAC - 1));
	localparam logic signed [SW-1:0] ONE        = SW'(1);

	function automatic logic signed [W-1:0] sat_fn(input logic signed [SW-1:0] x);
		logic signed [W-1:0] y;
		if (x > VMAX) begin
			y = VMAX[W-1:0];
		end else if (x < VMIN) begin
			y = VMIN[W-1:0];
		end else begin
			y = x[W-1:0];
		end
		return y;
	endfunction

	logic [RATIO_W-1:0]  ratio_q;
	logic signed [W-1:0] left_q, center_q, right_q;
	logic signed [W-1:0] fr_q, fc_q, fl_q, fup_q, fum_q;
	logic signed [W-1:0] d_q, p_q, up_q, um_q, res_q;
	logic signed [PW-1:0] prod_q;
	logic signed [W-1:0] out_value_q;
	logic                out_last_q;

	logic signed [W-1:0]  mul_a;
	logic signed [MB-1:0] mul_b;
	logic signed [SW-1:0] prod_x, flux_sum, ratio_sum, alu_x;
	logic signed [W-1:0]  flux_w, ratio_w, alu_y;

	// multiplier operand select
	always_comb begin
		unique case (cmd.mul_op)
			MUL_SQ_R:  begin mul_a = right_q;  mul_b = MB'(right_q);  end
			MUL_SQ_C:  begin mul_a = center_q; mul_b = MB'(center_q); end
			MUL_SQ_L:  begin mul_a = left_q;   mul_b = MB'(left_q);   end
			MUL_SQ_UP: begin mul_a = up_q;     mul_b = MB'(up_q);     end
			MUL_SQ_UM: begin mul_a = um_q;     mul_b = MB'(um_q);     end
			MUL_RD:    begin mul_a = d_q;      mul_b = signed'(MB'(ratio_q)); end
			default:   begin mul_a = '0;       mul_b = '0;            end
		endcase
	end

	// round half up then saturate the registered product
	always_comb begin
		prod_x    = SW'(prod_q);
		flux_sum  = prod_x + FLUX_HALF;
		ratio_sum = prod_x + RATIO_HALF;
		flux_w    = sat_fn(flux_sum >>> FLUX_SHIFT);
		ratio_w   = sat_fn(ratio_sum >>> RATIO_FRAC);
	end

	always_comb begin
		unique case (cmd.alu_op)
			ALU_D_RC:    alu_x = SW'(fr_q) - SW'(fc_q);
			ALU_D_CL:    alu_x = SW'(fc_q) - SW'(fl_q);
			ALU_D_UPUM:  alu_x = SW'(fup_q) - SW'(fum_q);
			ALU_FACE_UP: alu_x = (SW'(right_q) + SW'(center_q) - SW'(p_q) + ONE) >>> 1;
			ALU_FACE_UM: alu_x = (SW'(center_q) + SW'(left_q) - SW'(p_q) + ONE) >>> 1;
			ALU_UPDATE:  alu_x = SW'(center_q) - SW'(p_q);
			default:     alu_x = '0;
		endcase
		alu_y = sat_fn(alu_x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
		end else if (cfg_we) begin
			ratio_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		unique case (cmd.win_op)
			WIN_LOAD_C: center_q <= sample;
			WIN_SHIFT_IN: begin
				left_q   <= center_q;
				center_q <= sample;
			end
			WIN_LOAD_R: right_q <= sample;
			WIN_SHIFT_R: begin
				left_q   <= center_q;
				center_q <= right_q;
			end
			default: ;
		endcase

		unique case (cmd.wb_op)
			WB_F_R:  fr_q  <= flux_w;
			WB_F_C:  fc_q  <= flux_w;
			WB_F_L:  fl_q  <= flux_w;
			WB_F_UP: fup_q <= flux_w;
			WB_F_UM: fum_q <= flux_w;
			WB_P:    p_q   <= ratio_w;
			default: ;
		endcase

		unique case (cmd.alu_op)
			ALU_D_RC, ALU_D_CL, ALU_D_UPUM: d_q <= alu_y;
			ALU_FACE_UP: up_q  <= alu_y;
			ALU_FACE_UM: um_q  <= alu_y;
			ALU_UPDATE:  res_q <= alu_y;
			default: ;
		endcase

		unique case (cmd.out_sel)
			OUT_SAMPLE: begin
				out_value_q <= sample;
				out_last_q  <= cmd.out_last;
			end
			OUT_RESULT: begin
				out_value_q <= res_q;
				out_last_q  <= cmd.out_last;
			end
			OUT_RIGHT: begin
				out_value_q <= right_q;
				out_last_q  <= cmd.out_last;
			end
			default: ;
		endcase
	end

	assign new_value = out_value_q;
	assign last_out  = out_last_q;

endmodule

// File: src/bres_ctrl.sv
// ----------------------------------------------------------------------------
// bres_ctrl
// Row sequencer: tracks window fill, runs the 16-step update program on the
// datapath and owns both channel handshakes.
// ----------------------------------------------------------------------------
module bres_ctrl import bres_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_row_end,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output bres_cmd_t cmd
);

	localparam logic [1:0] S_IDLE     = 2'd0;
	localparam logic [1:0] S_CALC     = 2'd1;
	localparam logic [1:0] S_EMIT_UPD = 2'd2;
	localparam logic [1:0] S_EMIT_END = 2'd3;

	localparam logic [1:0] FILL_NONE = 2'd0;
	localparam logic [1:0] FILL_ONE  = 2'd1;
	localparam logic [1:0] FILL_TWO  = 2'd2;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NSTEPS - 1);

	// update program: mul issues, product written back in the next step
	function automatic bres_cmd_t step_cmd(input logic [STEP_W-1:0] step);
		bres_cmd_t c;
		c = CMD_IDLE;
		unique case (step)
			4'd0:  c.mul_op = MUL_SQ_R;
			4'd1:  begin c.wb_op = WB_F_R; c.mul_op = MUL_SQ_C; end
			4'd2:  begin c.wb_op = WB_F_C; c.mul_op = MUL_SQ_L; end
			4'd3:  begin c.wb_op = WB_F_L; c.alu_op = ALU_D_RC; end
			4'd4:  c.mul_op = MUL_RD;
			4'd5:  begin c.wb_op = WB_P; c.alu_op = ALU_D_CL; end
			4'd6:  begin c.mul_op = MUL_RD; c.alu_op = ALU_FACE_UP; end
			4'd7:  c.wb_op = WB_P;
			4'd8:  c.alu_op = ALU_FACE_UM;
			4'd9:  c.mul_op = MUL_SQ_UP;
			4'd10: begin c.wb_op = WB_F_UP; c.mul_op = MUL_SQ_UM; end
			4'd11: c.wb_op = WB_F_UM;
			4'd12: c.alu_op = ALU_D_UPUM;
			4'd13: c.mul_op = MUL_RD;
			4'd14: c.wb_op = WB_P;
			4'd15: c.alu_op = ALU_UPDATE;
		endcase
		return c;
	endfunction

	logic [1:0]        state_q, state_d;
	logic [1:0]        fill_q, fill_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              end_q, end_d;
	logic              out_valid_q;
	logic              slot_free, accept;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		fill_d  = fill_q;
		step_d  = step_q;
		end_d   = end_q;
		cmd     = CMD_IDLE;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (fill_q)
						FILL_NONE: begin
							cmd.out_sel  = OUT_SAMPLE;
							cmd.out_last = in_row_end;
							if (!in_row_end) begin
								cmd.win_op = WIN_LOAD_C;
								fill_d     = FILL_ONE;
							end
						end
						FILL_ONE: begin
							if (in_row_end) begin
								cmd.out_sel  = OUT_SAMPLE;
								cmd.out_last = 1'b1;
								fill_d       = FILL_NONE;
							end else begin
								cmd.win_op = WIN_SHIFT_IN;
								fill_d     = FILL_TWO;
							end
						end
						default: begin
							cmd.win_op = WIN_LOAD_R;
							end_d      = in_row_end;
							step_d     = '0;
							state_d    = S_CALC;
						end
					endcase
				end
			end
			S_CALC: begin
				cmd    = step_cmd(step_q);
				step_d = step_q + 1'b1;
				if (step_q == STEP_LAST) begin
					state_d = S_EMIT_UPD;
				end
			end
			S_EMIT_UPD: begin
				if (slot_free) begin
					cmd.out_sel = OUT_RESULT;
					if (end_q) begin
						fill_d  = FILL_NONE;
						state_d = S_EMIT_END;
					end else begin
						cmd.win_op = WIN_SHIFT_R;
						state_d    = S_IDLE;
					end
				end
			end
			S_EMIT_END: begin
				if (slot_free) begin
					cmd.out_sel  = OUT_RIGHT;
					cmd.out_last = 1'b1;
					state_d      = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= FILL_NONE;
			step_q      <= '0;
			end_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			step_q  <= step_d;
			end_q   <= end_d;
			if (cmd.out_sel != OUT_NONE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/burgers_richtmyer_stencil_step.sv
// ----------------------------------------------------------------------------
// burgers_richtmyer_stencil_step
// One Richtmyer two-step Lax-Wendroff step of inviscid Burgers on a streamed
// grid row, flux u*u/2, signed Q3.12 values, saturating arithmetic.
//
//   channel    dir  handshake            payload
//   samples    in   valid/ready          sample, row_end
//   results    out  valid/ready          new_value, last_out
//   ratio_cfg  in   valid/ready (rdy=1)  courant_ratio (UQ1.14)
//
// First and second points of a row are taken without a calculation. Each
// later point is accepted, runs 16 steps through the one shared multiplier
// (eight products), then the update leaves through the output register.
// A row-ending point also emits its pass-through result.
// Reset clears the row fill and sets the ratio to 0.9; results.ready low
// holds the output register and blocks the next request.
// ----------------------------------------------------------------------------
module burgers_richtmyer_stencil_step import bres_pkg::*; #(
	parameter int VALUE_WIDTH = 16
) (
	input logic       clk,
	input logic       arst_n,
	bres_in_if.sink   samples,
	bres_out_if.source results,
	bres_cfg_if.sink  ratio_cfg
);

	bres_cmd_t cmd;

	assign ratio_cfg.ready = 1'b1;

	bres_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_row_end(samples.row_end),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd)
	);

	bres_datapath #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sample   (samples.sample),
		.cfg_we   (ratio_cfg.valid),
		.cfg_data (ratio_cfg.courant_ratio),
		.new_value(results.new_value),
		.last_out (results.last_out)
	);

endmodule

// File: src/bres_checker.sv
// ----------------------------------------------------------------------------
// bres_checker
// Port-level checks on the stencil step, bound to the top level.
// ----------------------------------------------------------------------------
module bres_checker #(
	parameter int VALUE_WIDTH = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [VALUE_WIDTH-1:0] new_value,
	input logic                          last_out
);

	logic out_acc;
	assign out_acc = out_valid && out_ready;

	// a result waits until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(new_value) && $stable(last_out))
		else $error("result changed while stalled");

	// a stalled result blocks new requests
	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken while result stalled");

	// two results without last_out never leave on consecutive cycles
	a_update_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !last_out |=> !(out_acc && !last_out))
		else $error("back-to-back interior updates");

endmodule

bind burgers_richtmyer_stencil_step bres_checker #(
	.VALUE_WIDTH(VALUE_WIDTH)
) u_bres_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (samples.valid),
	.in_ready (samples.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.new_value(results.new_value),
	.last_out (results.last_out)
);
